// ===== rtl/assert_macros.svh =====
// assertion macros shared by the distinct colour tracker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define DCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define DCT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define DCT_ASSERT(lbl, prop, msg)

`define DCT_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== rtl/dct_pkg.sv =====
// shared types and constants for the distinct colour tracker
`timescale 1ns / 1ps

package dct_pkg;

  localparam int NUM_SLOTS_DEF  = 1024;
  localparam int NUM_COLORS_DEF = 1024;
  localparam int IN_W           = 10;
  localparam int OUT_W          = 11;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_DEC,
    ST_INC
  } state_e;

  typedef struct packed {
    logic clear;
    logic accept;
    logic fetch;
    logic dec;
    logic inc;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
  } status_t;

endpackage

// ===== rtl/dct_ctrl.sv =====
// sequencer for the distinct colour tracker: clearing sweep and per-beat steps
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dct_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  dct_pkg::status_t status_i,
  output dct_pkg::cmd_t  cmd_o,
  output logic           busy
);
  import dct_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_d = ST_FETCH;
      end
      ST_FETCH: state_d = ST_DEC;
      ST_DEC:   state_d = ST_INC;
      ST_INC:   state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      ST_CLEAR: cmd_o.clear = 1'b1;
      ST_IDLE: begin
        busy         = 1'b0;
        cmd_o.accept = start;
      end
      ST_FETCH: cmd_o.fetch = 1'b1;
      ST_DEC:   cmd_o.dec   = 1'b1;
      ST_INC:   cmd_o.inc   = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

  `DCT_ASSERT(a_accept_fetch, cmd_o.accept |=> state_q == ST_FETCH, "accepted beat not fetched")
  `DCT_ASSERT(a_inc_idle, state_q == ST_INC |=> state_q == ST_IDLE, "no return to idle")
  `DCT_ASSERT(a_clear_exit, state_q == ST_CLEAR |=> state_q == ST_CLEAR || state_q == ST_IDLE,
              "clear sweep left badly")

endmodule

// ===== rtl/dct_dp.sv =====
// datapath for the distinct colour tracker: slot and count memories, running total
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dct_dp #(
  parameter int NUM_SLOTS  = dct_pkg::NUM_SLOTS_DEF,
  parameter int NUM_COLORS = dct_pkg::NUM_COLORS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dct_pkg::cmd_t             cmd_i,
  output dct_pkg::status_t          status_o,
  input  logic [dct_pkg::IN_W-1:0]  slot_index_i,
  input  logic [dct_pkg::IN_W-1:0]  new_color_i,
  output logic                      done_o,
  output logic [dct_pkg::OUT_W-1:0] distinct_count_o
);
  import dct_pkg::*;

  localparam int SW        = $clog2(NUM_SLOTS);
  localparam int CW        = $clog2(NUM_COLORS);
  localparam int NW        = $clog2(NUM_SLOTS + 1);
  localparam int TW        = $clog2(NUM_COLORS + 1);
  localparam int DEPTH_MAX = (NUM_SLOTS > NUM_COLORS) ? NUM_SLOTS : NUM_COLORS;
  localparam int CLW       = $clog2(DEPTH_MAX);
  localparam int XSW       = (SW > IN_W) ? SW : IN_W;
  localparam int XCW       = (CW > IN_W) ? CW : IN_W;
  localparam int RW        = (TW > OUT_W) ? TW : OUT_W;

  logic [CW:0]   slot_mem [NUM_SLOTS];
  logic [NW-1:0] cnt_mem  [NUM_COLORS];

  logic [CLW-1:0] clr_q;
  logic [SW-1:0]  s_q;
  logic [CW-1:0]  c_q;
  logic           ok_q;
  logic [CW:0]    slot_rd_q;
  logic [NW-1:0]  cnt_q;
  logic [TW-1:0]  total_q, total_d;
  logic [OUT_W-1:0] res_q;
  logic           res_vld_q;

  logic [XSW-1:0] s_ext;
  logic [XCW-1:0] c_ext;
  logic           ok_d;
  logic           clr_in_slots, clr_in_colors;
  logic [CW-1:0]  prev;
  logic           prev_vld, same, dec_we, inc_we;
  logic           slot_we;
  logic [SW-1:0]  slot_waddr;
  logic [CW:0]    slot_wdata;
  logic           cnt_we, cnt_re;
  logic [CW-1:0]  cnt_waddr, cnt_raddr;
  logic [NW-1:0]  cnt_wdata;
  logic [RW-1:0]  tot_ext;

  assign s_ext = XSW'(slot_index_i);
  assign c_ext = XCW'(new_color_i);
  assign ok_d  = (32'(slot_index_i) < 32'(NUM_SLOTS)) && (32'(new_color_i) < 32'(NUM_COLORS));

  assign clr_in_slots  = 32'(clr_q) < 32'(NUM_SLOTS);
  assign clr_in_colors = 32'(clr_q) < 32'(NUM_COLORS);
  assign status_o.clr_done = (clr_q == CLW'(DEPTH_MAX - 1));

  assign prev     = slot_rd_q[CW-1:0];
  assign prev_vld = slot_rd_q[CW];
  assign same     = prev_vld && (prev == c_q);
  assign dec_we   = ok_q && prev_vld && !same;
  assign inc_we   = ok_q && !same;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + CLW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      s_q  <= s_ext[SW-1:0];
      c_q  <= c_ext[CW-1:0];
      ok_q <= ok_d;
    end
  end

  // slot memory: valid mark and colour per slot
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = s_q;
    slot_wdata = {1'b1, c_q};
    if (cmd_i.clear) begin
      slot_we    = clr_in_slots;
      slot_waddr = clr_q[SW-1:0];
      slot_wdata = '0;
    end else if (cmd_i.fetch) begin
      slot_we = ok_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (cmd_i.accept) slot_rd_q <= slot_mem[s_ext[SW-1:0]];
  end

  // count memory: one read port, one write port
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = c_q;
    cnt_wdata = cnt_q + NW'(1);
    if (cmd_i.clear) begin
      cnt_we    = clr_in_colors;
      cnt_waddr = clr_q[CW-1:0];
      cnt_wdata = '0;
    end else if (cmd_i.dec) begin
      cnt_we    = dec_we;
      cnt_waddr = prev;
      cnt_wdata = cnt_q - NW'(1);
    end else if (cmd_i.inc) begin
      cnt_we = inc_we;
    end
  end

  assign cnt_re    = cmd_i.fetch || cmd_i.dec;
  assign cnt_raddr = cmd_i.fetch ? prev : c_q;

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cnt_re) cnt_q <= cnt_mem[cnt_raddr];
  end

  always_comb begin
    total_d = total_q;
    if (cmd_i.dec && dec_we && (cnt_q == NW'(1))) total_d = total_q - TW'(1);
    if (cmd_i.inc && inc_we && (cnt_q == '0))     total_d = total_q + TW'(1);
  end

  assign tot_ext = RW'(total_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      total_q   <= total_d;
      res_vld_q <= cmd_i.inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.inc) res_q <= tot_ext[OUT_W-1:0];
  end

  assign done_o           = res_vld_q;
  assign distinct_count_o = res_q;

  `DCT_ASSERT(a_strobe_single, res_vld_q |=> !res_vld_q, "result strobe held too long")
  `DCT_ASSERT_NEVER(a_total_bound, total_q > TW'(NUM_COLORS), "total above colour count")
  `DCT_ASSERT(a_same_keeps_total, (cmd_i.dec || cmd_i.inc) && same |=> $stable(total_q),
              "recolour with same colour moved total")

endmodule

// ===== rtl/distinct_color_tracker.sv =====
// top level of the distinct colour tracker
`timescale 1ns / 1ps

// Each beat assigns new_color_i to slot slot_index_i and returns, one strobe
// done_o later, the number of distinct colours held over all slots. A beat is
// taken when start is high and busy is low; the result appears on
// distinct_count_o for the single cycle done_o is high and cannot be held off.
// From acceptance to result a beat passes through the slot memory read, then
// the previous colour's count read, its decrement, and the new colour's
// count update, all through the single read and write port of the count
// memory. The strobe cycle overlaps the idle cycle, so a new beat may be
// started while the result is shown; no beat is taken while busy is high.
// Out-of-range slots or colours change nothing and report the current total.
// After reset the block sweeps its valid marks and counts, one entry a cycle,
// over max(NUM_SLOTS, NUM_COLORS) entries with busy high.

module distinct_color_tracker #(
  parameter int NUM_SLOTS  = dct_pkg::NUM_SLOTS_DEF,
  parameter int NUM_COLORS = dct_pkg::NUM_COLORS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [dct_pkg::IN_W-1:0]  slot_index_i,
  input  logic [dct_pkg::IN_W-1:0]  new_color_i,
  output logic                      done_o,
  output logic [dct_pkg::OUT_W-1:0] distinct_count_o
);
  import dct_pkg::*;

  cmd_t    cmd;
  status_t status;

  dct_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  dct_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_COLORS (NUM_COLORS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .slot_index_i     (slot_index_i),
    .new_color_i      (new_color_i),
    .done_o           (done_o),
    .distinct_count_o (distinct_count_o)
  );

endmodule
